/* rtl/wct_pkg.sv */
// Package for the world-to-camera transform: shared widths, fixed-point
// constants, register indexes and the camera basis type.
// No dependencies.
`default_nettype none
package wct_pkg;

  localparam int COORD_BITS_DEF = 21;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int UNIT_SHIFT = 30;
  localparam int UNIT_W     = 32;
  localparam int NORM_HI    = 24;
  localparam int SQRT_PRE   = 12;
  localparam int DIV_SHIFT  = 36;
  localparam int LEN_W      = 32;
  localparam int ROOT_W     = 62;
  localparam int SUMSQ_W    = 50;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP  = 2'd2;

  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic                  degenerate;
    unit_t [2:0][2:0]      ax;
  } basis_t;

endpackage
`default_nettype wire

/* rtl/wct_norm.sv */
// Iterative vector normalizer: scale, sum of squares, bit-serial square root
// and bit-serial division per component. Uses wct_pkg.
`default_nettype none
module wct_norm #(
  parameter int DW = wct_pkg::COORD_BITS_DEF + 34
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [DW-1:0]      d [3],
  output logic                      done_r,
  output logic                      zero_r,
  output wct_pkg::unit_t            u_r [3]
);

  localparam int HI = wct_pkg::NORM_HI;
  localparam int RW = wct_pkg::ROOT_W;
  localparam int LW = wct_pkg::LEN_W;
  localparam int NW = HI + wct_pkg::DIV_SHIFT + 1;

  typedef enum logic [2:0] {N_IDLE, N_SCALE, N_SQ, N_SQRT, N_DIVLD, N_DIV, N_STORE} nst_t;

  nst_t                        st_r;
  logic [DW-1:0]               mag_r [3];
  logic                        neg_r [3];
  logic [1:0]                  idx_r;
  logic [4:0]                  cnt_r;
  logic [wct_pkg::SUMSQ_W-1:0] s_r;
  logic [RW-1:0]               x_r;
  logic [RW-1:0]               res_r;
  logic [RW-1:0]               bit_r;
  logic [LW-1:0]               rem_r;
  logic [LW-1:0]               lo_r;
  logic [LW-1:0]               q_r;

  logic [DW-1:0]               mx;
  logic [2*HI-1:0]             sq;
  logic [RW:0]                 trial_root;
  logic [LW-1:0]               len;
  logic [NW-1:0]               num;
  logic [LW:0]                 trial_div;
  logic [LW-1:0]               q_cap;

  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
    sq         = mag_r[idx_r][HI-1:0] * mag_r[idx_r][HI-1:0];
    trial_root = {1'b0, res_r} + {1'b0, bit_r};
    len        = res_r[LW-1:0];
    num        = {1'b0, mag_r[idx_r][HI-1:0], {wct_pkg::DIV_SHIFT{1'b0}}}
                 + NW'(len >> 1);
    trial_div  = {rem_r, lo_r[LW-1]};
    q_cap      = (q_r > (LW'(1) << wct_pkg::UNIT_SHIFT)) ?
                 (LW'(1) << wct_pkg::UNIT_SHIFT) : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= d[i][DW-1];
          mag_r[i] <= d[i][DW-1] ? (DW'(0) - d[i]) : d[i];
        end
        zero_r <= 1'b0;
        st_r   <= N_SCALE;
      end else begin
        unique case (st_r)
          N_IDLE: begin
          end
          N_SCALE: begin
            if (mx == '0) begin
              zero_r <= 1'b1;
              done_r <= 1'b1;
              st_r   <= N_IDLE;
            end else if (|mx[DW-1:HI]) begin
              for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
            end else if (!mx[HI-1]) begin
              for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
            end else begin
              s_r   <= '0;
              idx_r <= 2'd0;
              st_r  <= N_SQ;
            end
          end
          N_SQ: begin
            s_r   <= s_r + wct_pkg::SUMSQ_W'(sq);
            idx_r <= idx_r + 2'd1;
            if (idx_r == 2'd2) begin
              x_r   <= {s_r + wct_pkg::SUMSQ_W'(sq), {wct_pkg::SQRT_PRE{1'b0}}};
              res_r <= '0;
              bit_r <= RW'(1) << (RW - 2);
              st_r  <= N_SQRT;
            end
          end
          N_SQRT: begin
            if ({1'b0, x_r} >= trial_root) begin
              x_r   <= x_r - trial_root[RW-1:0];
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
            if (bit_r[0]) begin
              idx_r <= 2'd0;
              st_r  <= N_DIVLD;
            end
          end
          N_DIVLD: begin
            rem_r <= LW'(num[NW-1:LW]);
            lo_r  <= num[LW-1:0];
            q_r   <= '0;
            cnt_r <= '0;
            st_r  <= N_DIV;
          end
          N_DIV: begin
            if (trial_div >= {1'b0, len}) begin
              rem_r <= LW'(trial_div - {1'b0, len});
              q_r   <= {q_r[LW-2:0], 1'b1};
            end else begin
              rem_r <= trial_div[LW-1:0];
              q_r   <= {q_r[LW-2:0], 1'b0};
            end
            lo_r  <= lo_r << 1;
            cnt_r <= cnt_r + 5'd1;
            if (cnt_r == 5'd31) st_r <= N_STORE;
          end
          N_STORE: begin
            u_r[idx_r] <= neg_r[idx_r] ? -$signed(q_cap) : $signed(q_cap);
            if (idx_r == 2'd2) begin
              done_r <= 1'b1;
              st_r   <= N_IDLE;
            end else begin
              idx_r <= idx_r + 2'd1;
              st_r  <= N_DIVLD;
            end
          end
          default: st_r <= N_IDLE;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/wct_basis.sv */
// Camera basis sequencer: forward, side and third axes from eye, at and up,
// through one shared multiplier and wct_norm. Uses wct_pkg.
`default_nettype none
module wct_basis #(
  parameter int COORD_BITS = wct_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic signed [COORD_BITS-1:0]  eye [3],
  input  logic signed [COORD_BITS-1:0]  at [3],
  input  logic signed [COORD_BITS-1:0]  up [3],
  output logic                          rdy_r,
  output wct_pkg::basis_t               bas_r
);

  localparam int DW = COORD_BITS + 34;
  localparam int UW = wct_pkg::UNIT_W;
  localparam int PW = 2 * UW;
  localparam int TW = PW + 1;
  localparam int US = wct_pkg::UNIT_SHIFT;

  typedef enum logic [2:0] {B_IDLE, B_K, B_NK, B_C1, B_TL, B_NI, B_C2, B_RND} bst_t;

  bst_t                   st_r;
  logic                   nstart_r;
  logic signed [DW-1:0]   nd_r [3];
  wct_pkg::unit_t         a_r [3];
  wct_pkg::unit_t         b_r [3];
  wct_pkg::unit_t         nk_r [3];
  wct_pkg::unit_t         ni_r [3];
  logic signed [PW-1:0]   p_r;
  logic signed [TW-1:0]   t_r [3];
  logic [2:0]             cnt_r;

  logic                   ndone;
  logic                   nzero;
  wct_pkg::unit_t         nu [3];
  logic [1:0]             c;
  logic [1:0]             i1;
  logic [1:0]             i2;
  wct_pkg::unit_t         ma;
  wct_pkg::unit_t         mb;
  logic signed [PW-1:0]   prod;
  logic [TW-1:0]          tmag [3];
  logic [TW-1:0]          rmag [3];
  wct_pkg::unit_t         nj [3];

  function automatic logic [1:0] next3(input logic [1:0] x);
    logic [1:0] y;
    case (x)
      2'd0:    y = 2'd1;
      2'd1:    y = 2'd2;
      default: y = 2'd0;
    endcase
    return y;
  endfunction

  wct_norm #(.DW(DW)) u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (nstart_r),
    .d      (nd_r),
    .done_r (ndone),
    .zero_r (nzero),
    .u_r    (nu)
  );

  always_comb begin
    c    = cnt_r[2:1];
    i1   = next3(c);
    i2   = next3(i1);
    ma   = cnt_r[0] ? a_r[i2] : a_r[i1];
    mb   = cnt_r[0] ? b_r[i1] : b_r[i2];
    prod = ma * mb;
    for (int i = 0; i < 3; i++) begin
      tmag[i] = t_r[i][TW-1] ? TW'(-t_r[i]) : TW'(t_r[i]);
      rmag[i] = (tmag[i] + (TW'(1) << (US - 1))) >> US;
      nj[i]   = t_r[i][TW-1] ? -$signed(rmag[i][UW-1:0]) : $signed(rmag[i][UW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      rdy_r    <= 1'b0;
      nstart_r <= 1'b0;
    end else begin
      nstart_r <= 1'b0;
      if (restart) begin
        rdy_r <= 1'b0;
        st_r  <= B_K;
      end else begin
        unique case (st_r)
          B_IDLE: begin
          end
          B_K: begin
            for (int i = 0; i < 3; i++) begin
              nd_r[i] <= DW'(eye[i]) - DW'(at[i]);
              a_r[i]  <= UW'(up[i]) - UW'(eye[i]);
            end
            nstart_r <= 1'b1;
            st_r     <= B_NK;
          end
          B_NK: begin
            if (ndone && !nstart_r) begin
              if (nzero) begin
                bas_r.degenerate <= 1'b1;
                rdy_r            <= 1'b1;
                st_r             <= B_IDLE;
              end else begin
                b_r   <= nu;
                nk_r  <= nu;
                cnt_r <= '0;
                st_r  <= B_C1;
              end
            end
          end
          B_C1, B_C2: begin
            if (!cnt_r[0]) p_r <= prod;
            else           t_r[c] <= TW'(p_r) - TW'(prod);
            cnt_r <= cnt_r + 3'd1;
            if (cnt_r == 3'd5) st_r <= (st_r == B_C1) ? B_TL : B_RND;
          end
          B_TL: begin
            for (int i = 0; i < 3; i++) nd_r[i] <= t_r[i][DW-1:0];
            nstart_r <= 1'b1;
            st_r     <= B_NI;
          end
          B_NI: begin
            if (ndone && !nstart_r) begin
              if (nzero) begin
                bas_r.degenerate <= 1'b1;
                rdy_r            <= 1'b1;
                st_r             <= B_IDLE;
              end else begin
                ni_r  <= nu;
                a_r   <= nk_r;
                b_r   <= nu;
                cnt_r <= '0;
                st_r  <= B_C2;
              end
            end
          end
          B_RND: begin
            for (int i = 0; i < 3; i++) begin
              bas_r.ax[0][i] <= ni_r[i];
              bas_r.ax[1][i] <= nj[i];
              bas_r.ax[2][i] <= nk_r[i];
            end
            bas_r.degenerate <= 1'b0;
            rdy_r            <= 1'b1;
            st_r             <= B_IDLE;
          end
          default: st_r <= B_IDLE;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/wct_dot.sv */
// Four-stage point pipeline: offset from eye, nine products, sums, rounding
// with saturation. Uses wct_pkg for the basis type and unit scale.
`default_nettype none
module wct_dot #(
  parameter int COORD_BITS = wct_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [COORD_BITS-1:0]  w [3],
  input  logic signed [COORD_BITS-1:0]  eye [3],
  input  wct_pkg::basis_t               bas,
  output logic                          vld_r,
  output logic signed [COORD_BITS-1:0]  cam_r [3],
  output logic                          deg_r
);

  localparam int RW = COORD_BITS + 1;
  localparam int PW = wct_pkg::UNIT_W + RW;
  localparam int SW = PW + 2;
  localparam int US = wct_pkg::UNIT_SHIFT;
  localparam int QW = SW - US;

  logic                  v1_r;
  logic                  v2_r;
  logic                  v3_r;
  logic signed [RW-1:0]  rel1_r [3];
  logic signed [PW-1:0]  prod2_r [3][3];
  logic signed [SW-1:0]  sum3_r [3];

  logic [SW-1:0]         mag [3];
  logic [QW-1:0]         rq [3];
  logic signed [COORD_BITS-1:0] sat [3];

  localparam logic [QW-1:0] POS_MAX = QW'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam logic [QW-1:0] NEG_MAX = QW'(64'd1 << (COORD_BITS - 1));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = sum3_r[a][SW-1] ? SW'(-sum3_r[a]) : SW'(sum3_r[a]);
      rq[a]  = QW'((mag[a] + (SW'(1) << (US - 1))) >> US);
      if (sum3_r[a][SW-1]) begin
        sat[a] = (rq[a] > NEG_MAX) ? -$signed(NEG_MAX[COORD_BITS-1:0])
                                   : -$signed(rq[a][COORD_BITS-1:0]);
      end else begin
        sat[a] = (rq[a] > POS_MAX) ? $signed(POS_MAX[COORD_BITS-1:0])
                                   : $signed(rq[a][COORD_BITS-1:0]);
      end
      if (bas.degenerate) sat[a] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      vld_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_vld;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      vld_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 3; b++) rel1_r[b] <= RW'(w[b]) - RW'(eye[b]);
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          prod2_r[a][b] <= $signed(bas.ax[a][b]) * rel1_r[b];
        end
        sum3_r[a] <= SW'(prod2_r[a][0]) + SW'(prod2_r[a][1]) + SW'(prod2_r[a][2]);
        cam_r[a]  <= sat[a];
      end
      deg_r <= bas.degenerate;
    end
  end

endmodule
`default_nettype wire

/* rtl/world_to_camera_transform.sv */
// Top level of the world-to-camera transform: configuration registers, basis
// sequencer (wct_basis) and point pipeline (wct_dot). Uses wct_pkg.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   in_world_x, in_world_y, in_world_z
//   out_      output     out_valid / out_ready out_cam_x/y/z, out_degenerate
//   cfg_      input      cfg_we                cfg_idx, cfg_wdata
//
// One point per cycle while the output is not stalled and the basis is ready.
// A stall on out_ready freezes all four stages together; nothing is lost.
// After reset and after each register write the basis sequencer runs two
// normalizations (shift scaling, 31 root steps and three divides each), and
// in_ready stays low until it finishes.
`default_nettype none
module world_to_camera_transform #(
  parameter int COORD_BITS = wct_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = wct_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       in_world_x,
  input  logic signed [COORD_BITS-1:0]       in_world_y,
  input  logic signed [COORD_BITS-1:0]       in_world_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_BITS-1:0]       out_cam_x,
  output logic signed [COORD_BITS-1:0]       out_cam_y,
  output logic signed [COORD_BITS-1:0]       out_cam_z,
  output logic                               out_degenerate,
  input  logic                               cfg_we,
  input  logic [wct_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [3*COORD_BITS-1:0]            cfg_wdata
);

  localparam int CW = 3 * COORD_BITS;
  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1) << FRAC_BITS;

  logic [CW-1:0]                 eye_r;
  logic [CW-1:0]                 at_r;
  logic [CW-1:0]                 up_r;
  logic                          restart_r;

  logic signed [COORD_BITS-1:0]  eye [3];
  logic signed [COORD_BITS-1:0]  at [3];
  logic signed [COORD_BITS-1:0]  up [3];
  logic signed [COORD_BITS-1:0]  w [3];
  logic signed [COORD_BITS-1:0]  cam [3];
  logic                          bas_rdy;
  wct_pkg::basis_t               bas;
  logic                          en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r     <= {ONE, {COORD_BITS{1'b0}}, {COORD_BITS{1'b0}}};
      at_r      <= '0;
      up_r      <= {ONE, ONE, {COORD_BITS{1'b0}}};
      restart_r <= 1'b1;
    end else begin
      restart_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          wct_pkg::CFG_EYE: begin
            eye_r     <= cfg_wdata;
            restart_r <= 1'b1;
          end
          wct_pkg::CFG_AT: begin
            at_r      <= cfg_wdata;
            restart_r <= 1'b1;
          end
          wct_pkg::CFG_UP: begin
            up_r      <= cfg_wdata;
            restart_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye[i] = $signed(eye_r[i*COORD_BITS +: COORD_BITS]);
      at[i]  = $signed(at_r[i*COORD_BITS +: COORD_BITS]);
      up[i]  = $signed(up_r[i*COORD_BITS +: COORD_BITS]);
    end
    w[0] = in_world_x;
    w[1] = in_world_y;
    w[2] = in_world_z;
  end

  wct_basis #(.COORD_BITS(COORD_BITS)) u_basis (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart_r),
    .eye     (eye),
    .at      (at),
    .up      (up),
    .rdy_r   (bas_rdy),
    .bas_r   (bas)
  );

  assign en       = !out_valid || out_ready;
  assign in_ready = en && bas_rdy && !restart_r;

  wct_dot #(.COORD_BITS(COORD_BITS)) u_dot (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid && in_ready),
    .w      (w),
    .eye    (eye),
    .bas    (bas),
    .vld_r  (out_valid),
    .cam_r  (cam),
    .deg_r  (out_degenerate)
  );

  assign out_cam_x = cam[0];
  assign out_cam_y = cam[1];
  assign out_cam_z = cam[2];

`ifndef SYNTHESIS
  a_ready_needs_basis: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> bas_rdy)
    else $error("input taken before basis ready");
  a_restart_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    restart_r |-> !in_ready)
    else $error("input taken during basis restart");
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_cam_x == '0 && out_cam_y == '0 &&
                                       out_cam_z == '0))
    else $error("degenerate result not zero");
  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_idx == wct_pkg::CFG_EYE || cfg_idx == wct_pkg::CFG_AT ||
                cfg_idx == wct_pkg::CFG_UP)) |=> !bas_rdy || restart_r)
    else $error("register write did not restart basis");
`endif

endmodule
`default_nettype wire

/* dv/wct_checker.sv */
// Checker for the world-to-camera transform: tracks the eye, look-at and up
// registers, predicts camera coordinates per point and compares results.
// Depends on wct_pkg.
module wct_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [20:0] in_world_x,
  input  logic [20:0] in_world_y,
  input  logic [20:0] in_world_z,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [20:0] out_cam_x,
  input  logic [20:0] out_cam_y,
  input  logic [20:0] out_cam_z,
  input  logic        out_degenerate,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [62:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef longint vec_t [3];
  typedef struct packed {
    logic [20:0] x;
    logic [20:0] y;
    logic [20:0] z;
    logic        degen;
  } cam_t;

  localparam logic [62:0] ONE_Q = 63'd256;

  logic [62:0] eye_reg, at_reg, up_reg;
  cam_t        cam_q[$];

  function automatic longint coord(input logic [62:0] p, input int n);
    logic [20:0] c;
    c = p[n*21 +: 21];
    return longint'($signed(c));
  endfunction

  function automatic longint unsigned root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_away(input longint v, input int n);
    longint unsigned mag, r;
    mag = (v < 0) ? 64'd0 - 64'(v) : 64'(v);
    r = (mag + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic bit unit_vec(input vec_t d, output vec_t u);
    longint unsigned m[3], mx, s, len, q;
    mx = 0;
    s = 0;
    for (int a = 0; a < 3; a++) begin
      m[a] = (d[a] < 0) ? 64'd0 - 64'(d[a]) : 64'(d[a]);
      if (m[a] > mx) mx = m[a];
      u[a] = 0;
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 24)) begin
      mx = mx >> 1;
      for (int a = 0; a < 3; a++) m[a] = m[a] >> 1;
    end
    while (mx < (64'd1 << 23)) begin
      mx = mx << 1;
      for (int a = 0; a < 3; a++) m[a] = m[a] << 1;
    end
    for (int a = 0; a < 3; a++) s = s + m[a] * m[a];
    len = root(s << wct_pkg::SQRT_PRE);
    for (int a = 0; a < 3; a++) begin
      q = ((m[a] << wct_pkg::DIV_SHIFT) + (len >> 1)) / len;
      if (q > (64'd1 << wct_pkg::UNIT_SHIFT)) q = 64'd1 << wct_pkg::UNIT_SHIFT;
      u[a] = (d[a] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic vec_t cross3(input vec_t a, input vec_t b);
    vec_t c;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    return c;
  endfunction

  function automatic logic [20:0] clamp21(input longint v);
    if (v > 1048575) v = 1048575;
    if (v < -1048576) v = -1048576;
    return v[20:0];
  endfunction

  function automatic cam_t view_point(input logic [20:0] wx, input logic [20:0] wy,
                                      input logic [20:0] wz);
    vec_t   k, vu, rel, fwd, side, t, third;
    longint acc;
    cam_t   r;
    logic [62:0] w;
    w = {wz, wy, wx};
    for (int a = 0; a < 3; a++) begin
      k[a]   = coord(eye_reg, a) - coord(at_reg, a);
      vu[a]  = coord(up_reg, a) - coord(eye_reg, a);
      rel[a] = coord(w, a) - coord(eye_reg, a);
    end
    r = '{x: '0, y: '0, z: '0, degen: 1'b1};
    if (!unit_vec(k, fwd)) return r;
    t = cross3(vu, fwd);
    if (!unit_vec(t, side)) return r;
    t = cross3(fwd, side);
    for (int a = 0; a < 3; a++) third[a] = round_away(t[a], wct_pkg::UNIT_SHIFT);
    acc = side[0] * rel[0] + side[1] * rel[1] + side[2] * rel[2];
    r.x = clamp21(round_away(acc, wct_pkg::UNIT_SHIFT));
    acc = third[0] * rel[0] + third[1] * rel[1] + third[2] * rel[2];
    r.y = clamp21(round_away(acc, wct_pkg::UNIT_SHIFT));
    acc = fwd[0] * rel[0] + fwd[1] * rel[1] + fwd[2] * rel[2];
    r.z = clamp21(round_away(acc, wct_pkg::UNIT_SHIFT));
    r.degen = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    cam_t want;
    if (!rst_n) begin
      eye_reg = ONE_Q << 42;
      at_reg  = '0;
      up_reg  = (ONE_Q << 42) | (ONE_Q << 21);
      cam_q.delete();
      errors  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          wct_pkg::CFG_EYE: eye_reg = cfg_wdata;
          wct_pkg::CFG_AT:  at_reg  = cfg_wdata;
          wct_pkg::CFG_UP:  up_reg  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) cam_q.push_back(view_point(in_world_x, in_world_y, in_world_z));
      if (out_valid && out_ready) begin
        if (cam_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction: cam %h %h %h degen %b",
                                     out_cam_x, out_cam_y, out_cam_z, out_degenerate);
        end else begin
          want = cam_q.pop_front();
          if (want.x !== out_cam_x || want.y !== out_cam_y || want.z !== out_cam_z ||
              want.degen !== out_degenerate) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h %h %h degen %b, got %h %h %h degen %b",
                       want.x, want.y, want.z, want.degen,
                       out_cam_x, out_cam_y, out_cam_z, out_degenerate);
          end
        end
      end
    end
    pending = cam_q.size();
  end
endmodule

/* dv/tb.sv */
// Testbench top for world_to_camera_transform: clock, reset, point and
// register stimulus under varying idle patterns, watchdog and verdict.
// Depends on wct_pkg, world_to_camera_transform and wct_checker.
module tb;

  localparam logic [wct_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam logic [20:0] C_MAX = 21'h0FFFFF;
  localparam logic [20:0] C_MIN = 21'h100000;
  localparam int WATCH_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [20:0] in_world_x = '0, in_world_y = '0, in_world_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] out_cam_x, out_cam_y, out_cam_z;
  logic        out_degenerate;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [62:0] cfg_wdata = '0;
  int          errors, pending;
  int          idle_pct = 0, stall_pct = 0, quiet_cycles = 0;

  always #4 clk = ~clk;

  world_to_camera_transform dut (.*);

  wct_checker chk (.*);

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("FAIL world_to_camera_transform");
      $finish;
    end
  end

  function automatic logic [62:0] pack3(input logic [20:0] x, input logic [20:0] y,
                                        input logic [20:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [20:0] rand_coord(input bit narrow);
    if (narrow) return 21'($signed($urandom_range(8192)) - 4096);
    return 21'($urandom);
  endfunction

  task automatic send_point(input logic [20:0] x, input logic [20:0] y, input logic [20:0] z);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_world_x <= x;
    in_world_y <= y;
    in_world_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [62:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_camera(input logic [62:0] e, input logic [62:0] a, input logic [62:0] u);
    drain();
    write_reg(wct_pkg::CFG_EYE, e);
    write_reg(wct_pkg::CFG_AT, a);
    write_reg(wct_pkg::CFG_UP, u);
  endtask

  task automatic set_idle(input int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 87; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 87; end
      default: begin idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  initial begin
    bit narrow;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_point('0, '0, '0);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, C_MIN, '0);
    send_point(C_MIN, '0, C_MAX);
    send_point('0, C_MAX, C_MIN);
    send_point(21'd256, 21'd256, 21'd256);
    send_point(21'h1FFFFF, 21'd1, 21'h1FFFFF);

    // eye on the look-at point, then view-up along the forward axis
    load_camera(pack3(21'd100, 21'd200, 21'd300), pack3(21'd100, 21'd200, 21'd300),
                pack3('0, 21'd256, '0));
    send_point(21'd5, 21'd6, 21'd7);
    send_point(C_MAX, C_MIN, C_MAX);
    load_camera(pack3('0, '0, 21'd256), '0, pack3('0, '0, 21'd512));
    send_point(21'd5, 21'd6, 21'd7);
    send_point(C_MIN, C_MAX, C_MIN);
    drain();
    write_reg(CFG_NONE, '1);
    send_point(21'd9, 21'd9, 21'd9);

    load_camera(pack3(C_MAX, C_MAX, C_MAX), pack3(C_MIN, C_MIN, C_MIN),
                pack3(C_MIN, C_MAX, '0));
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point('0, '0, '0);
    load_camera(pack3(C_MIN, '0, C_MAX), pack3(C_MAX, C_MIN, '0),
                pack3(C_MAX, C_MAX, C_MAX));
    send_point(C_MIN, C_MAX, C_MIN);
    send_point('0, '0, '0);

    for (int phase = 0; phase < 12; phase++) begin
      narrow = ($urandom_range(2) != 0);
      load_camera(pack3(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow)),
                  pack3(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow)),
                  pack3(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow)));
      set_idle(phase);
      for (int n = 0; n < 118; n++) begin
        narrow = ($urandom_range(3) != 0);
        send_point(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS world_to_camera_transform");
    else $display("FAIL world_to_camera_transform");
    $finish;
  end
endmodule

/* filelist.f */
rtl/wct_pkg.sv
rtl/wct_norm.sv
rtl/wct_basis.sv
rtl/wct_dot.sv
rtl/world_to_camera_transform.sv
dv/wct_checker.sv
dv/tb.sv
